// ===== rtl/tlbpt_pkg.sv =====
// shared types and constants for the tlb page translation block
package tlbpt_pkg;

	localparam int unsigned ADDR_BITS   = 16;
	localparam int unsigned OFFSET_BITS = 12;
	localparam int unsigned PAGE_BITS   = ADDR_BITS - OFFSET_BITS;
	localparam int unsigned FRAME_BITS  = 4;
	localparam int unsigned MAP_BITS    = 64;
	localparam int unsigned MASK_BITS   = 16;
	localparam int unsigned CFG_ADDR_BITS = 2;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_FRAME_MAP   = 2'd0,
		REG_VALID_MASK  = 2'd1,
		REG_ACCESS_MASK = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_PROT_FAULT = 2'd1,
		STATUS_SEG_FAULT  = 2'd2
	} status_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_in;
		logic advance;
	} dp_cmd_t;

endpackage

// ===== rtl/tlbpt_ctrl.sv =====
// controller: tracks the held input word and the output register
module tlbpt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output tlbpt_pkg::dp_cmd_t  cmd
);

	typedef enum logic {
		ST_EMPTY,
		ST_HELD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free     = !out_valid_q || !out_stall;
	assign cmd.advance  = (state_q == ST_HELD) && out_free;
	assign in_stall     = (state_q == ST_HELD) && !out_free;
	assign cmd.load_in  = in_valid && !in_stall;
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_EMPTY;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_EMPTY: begin
					if (cmd.load_in) begin
						state_q <= ST_HELD;
					end
				end
				ST_HELD: begin
					if (cmd.advance && !cmd.load_in) begin
						state_q <= ST_EMPTY;
					end
				end
				default: begin
					state_q <= ST_EMPTY;
				end
			endcase
			if (cmd.advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/tlbpt_datapath.sv =====
// datapath: config registers, tlb entries, lookup and result register
module tlbpt_datapath #(
	parameter int TLB_ENTRIES = 8,
	parameter int NUM_PAGES   = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  tlbpt_pkg::dp_cmd_t                       cmd,
	input  logic                                     cfg_write,
	input  logic [tlbpt_pkg::CFG_ADDR_BITS-1:0]      cfg_addr,
	input  logic [tlbpt_pkg::MAP_BITS-1:0]           cfg_data,
	input  logic [tlbpt_pkg::ADDR_BITS-1:0]          logical_address,
	output logic [tlbpt_pkg::ADDR_BITS-1:0]          physical_address,
	output logic                                     tlb_hit,
	output logic [1:0]                               status
);

	localparam int SLOT_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

	logic [tlbpt_pkg::MAP_BITS-1:0]    frame_map_q;
	logic [tlbpt_pkg::MASK_BITS-1:0]   valid_mask_q;
	logic [tlbpt_pkg::MASK_BITS-1:0]   access_mask_q;

	logic [tlbpt_pkg::PAGE_BITS-1:0]   tlb_tag_q   [TLB_ENTRIES];
	logic [tlbpt_pkg::FRAME_BITS-1:0]  tlb_frame_q [TLB_ENTRIES];
	logic [TLB_ENTRIES-1:0]            tlb_valid_q;
	logic [SLOT_W-1:0]                 fifo_next_q;

	logic [tlbpt_pkg::ADDR_BITS-1:0]   addr_s1;
	logic [tlbpt_pkg::ADDR_BITS-1:0]   phys_q;
	logic                              hit_q;
	tlbpt_pkg::status_t                status_q;

	logic [tlbpt_pkg::PAGE_BITS-1:0]   page;
	logic [tlbpt_pkg::OFFSET_BITS-1:0] offset;
	logic                              hit;
	logic [tlbpt_pkg::FRAME_BITS-1:0]  hit_frame;
	logic [tlbpt_pkg::FRAME_BITS-1:0]  map_frame;
	logic [tlbpt_pkg::FRAME_BITS-1:0]  frame;
	logic                              allowed;
	logic                              page_valid;
	logic                              fill;
	tlbpt_pkg::status_t                status_d;

	assign page   = addr_s1[tlbpt_pkg::ADDR_BITS-1:tlbpt_pkg::OFFSET_BITS];
	assign offset = addr_s1[tlbpt_pkg::OFFSET_BITS-1:0];

	// associative search, lowest matching slot wins
	always_comb begin
		hit       = 1'b0;
		hit_frame = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			if (tlb_valid_q[i] && tlb_tag_q[i] == page) begin
				hit       = 1'b1;
				hit_frame = tlb_frame_q[i];
			end
		end
	end

	assign map_frame  = frame_map_q[page * tlbpt_pkg::FRAME_BITS +: tlbpt_pkg::FRAME_BITS];
	assign allowed    = access_mask_q[page];
	assign page_valid = ({1'b0, page} < (tlbpt_pkg::PAGE_BITS + 1)'(NUM_PAGES))
		&& valid_mask_q[page];
	assign frame      = hit ? hit_frame : map_frame;

	always_comb begin
		if (hit) begin
			status_d = allowed ? tlbpt_pkg::STATUS_OK : tlbpt_pkg::STATUS_PROT_FAULT;
		end else if (!page_valid) begin
			status_d = tlbpt_pkg::STATUS_SEG_FAULT;
		end else if (!allowed) begin
			status_d = tlbpt_pkg::STATUS_PROT_FAULT;
		end else begin
			status_d = tlbpt_pkg::STATUS_OK;
		end
	end

	assign fill = cmd.advance && !hit && status_d == tlbpt_pkg::STATUS_OK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_map_q   <= '0;
			valid_mask_q  <= '0;
			access_mask_q <= '0;
			tlb_valid_q   <= '0;
			fifo_next_q   <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_addr)
					tlbpt_pkg::REG_FRAME_MAP: begin
						frame_map_q <= cfg_data;
					end
					tlbpt_pkg::REG_VALID_MASK: begin
						valid_mask_q <= cfg_data[tlbpt_pkg::MASK_BITS-1:0];
					end
					tlbpt_pkg::REG_ACCESS_MASK: begin
						access_mask_q <= cfg_data[tlbpt_pkg::MASK_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
			if (fill) begin
				tlb_valid_q[fifo_next_q] <= 1'b1;
				if (fifo_next_q == SLOT_W'(TLB_ENTRIES - 1)) begin
					fifo_next_q <= '0;
				end else begin
					fifo_next_q <= fifo_next_q + 1'b1;
				end
			end
		end
	end

	// tlb payload and word registers
	always_ff @(posedge clk) begin
		if (fill) begin
			tlb_tag_q[fifo_next_q]   <= page;
			tlb_frame_q[fifo_next_q] <= map_frame;
		end
		if (cmd.load_in) begin
			addr_s1 <= logical_address;
		end
		if (cmd.advance) begin
			phys_q   <= (status_d == tlbpt_pkg::STATUS_OK) ? {frame, offset} : '0;
			hit_q    <= hit;
			status_q <= status_d;
		end
	end

	assign physical_address = phys_q;
	assign tlb_hit          = hit_q;
	assign status           = status_q;

endmodule

// ===== rtl/tlb_page_translate.sv =====
// top level of the tlb page translation block
//
// input channel: in_valid / in_stall carry one 16-bit logical_address word.
// output channel: out_valid / out_stall carry physical_address, tlb_hit and
// status (ok, protection fault, segmentation fault) for each input word.
// configuration: cfg_write with cfg_addr selects frame_map (0), valid_mask (1)
// or access_mask (2); other indexes are ignored. write only while idle.
// an accepted word is held in the input register (addr_s1), then translated
// and its result is captured in the output register.
// throughput: one word per cycle while the output is not stalled; the 8-way tag
// compare, the page table checks and the fifo fill of the tlb all happen in
// the same cycle, so the next word sees the updated tlb.
// a stalled result holds in the output register; one more word waits in the
// input register, then in_stall rises until the output is taken.
// reset clears the configuration registers, all tlb valid bits and the fifo
// pointer; the block takes words in the first cycle after reset.
// faults return address zero and leave the tlb untouched.
module tlb_page_translate #(
	parameter int TLB_ENTRIES = 8,
	parameter int NUM_PAGES   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [tlbpt_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [tlbpt_pkg::MAP_BITS-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [tlbpt_pkg::ADDR_BITS-1:0]     logical_address,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tlbpt_pkg::ADDR_BITS-1:0]     physical_address,
	output logic                                tlb_hit,
	output logic [1:0]                          status
);

	tlbpt_pkg::dp_cmd_t cmd;

	tlbpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	tlbpt_datapath #(
		.TLB_ENTRIES (TLB_ENTRIES),
		.NUM_PAGES   (NUM_PAGES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg_write        (cfg_write),
		.cfg_addr         (cfg_addr),
		.cfg_data         (cfg_data),
		.logical_address  (logical_address),
		.physical_address (physical_address),
		.tlb_hit          (tlb_hit),
		.status           (status)
	);

endmodule

// ===== rtl/tlbpt_checker.sv =====
// port-level checks for the tlb page translation block
module tlbpt_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [tlbpt_pkg::ADDR_BITS-1:0]     physical_address,
	input logic                                tlb_hit,
	input logic [1:0]                          status
);

	// a stalled result stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(physical_address)
			&& $stable(tlb_hit) && $stable(status))
		else $error("stalled result word changed");

	// a fault never leaks an address
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != tlbpt_pkg::STATUS_OK |-> physical_address == '0)
		else $error("faulting word has nonzero address");

	// only defined status codes, and a tlb hit is never a segmentation fault
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == tlbpt_pkg::STATUS_OK
			|| status == tlbpt_pkg::STATUS_PROT_FAULT
			|| (status == tlbpt_pkg::STATUS_SEG_FAULT && !tlb_hit)))
		else $error("bad status on result word");

	// a rising out_valid must match an earlier accepted input word
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result word without matching input word");

endmodule

bind tlb_page_translate tlbpt_checker u_tlbpt_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.physical_address (physical_address),
	.tlb_hit          (tlb_hit),
	.status           (status)
);
